// ===== rtl/core/y2r_pkg.sv =====
package y2r_pkg;

    // Field widths fixed by the pixel format and the register map
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned COEF_W = 15;
    localparam int unsigned IDX_W  = 3;

    // Chroma samples carry an offset of 128
    localparam logic [PIX_W-1:0] CHROMA_OFFSET = 8'd128;

    // Largest byte value, used by the clamp
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_CR_TO_RED   = 3'd0,
        REG_CB_TO_GREEN = 3'd1,
        REG_CR_TO_GREEN = 3'd2,
        REG_CB_TO_BLUE  = 3'd3
    } reg_index_t;

    // Reset gains, 14 fractional bits (1.402, 0.34414, 0.71414, 1.772)
    localparam logic [COEF_W-1:0] RST_CR_TO_RED   = 15'd22970;
    localparam logic [COEF_W-1:0] RST_CB_TO_GREEN = 15'd5638;
    localparam logic [COEF_W-1:0] RST_CR_TO_GREEN = 15'd11700;
    localparam logic [COEF_W-1:0] RST_CB_TO_BLUE  = 15'd29032;

    // Gain registers as one group
    typedef struct packed {
        logic [COEF_W-1:0] cr_to_red;
        logic [COEF_W-1:0] cb_to_green;
        logic [COEF_W-1:0] cr_to_green;
        logic [COEF_W-1:0] cb_to_blue;
    } coef_set_t;

endpackage

// ===== rtl/core/yuyv_to_rgb888_converter_core.sv =====
// YUYV 4:2:2 to RGB888 colour converter core (full-range BT.601 / JFIF).
// Input channel: present one macropixel (luma_first, chroma_blue, luma_second,
// chroma_red) with start high; the word is taken at any rising edge where
// start is high and busy is low. busy is always low: the four-stage pipeline
// (input/offset, gain multipliers, channel sums, shift and clamp) takes a new
// word every cycle, so throughput is one macropixel per clock.
// Result channel: done is high for exactly one cycle with the two RGB888
// pixels on the result ports; each word passes the input, product, sum and
// output registers in order. Results leave in input order and cannot be
// held off, so the pipeline never stalls.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Indexes 0..3 select the four gain registers
// (red from Cr, green from Cb, green from Cr, blue from Cb), other indexes
// are ignored. Write gains only while no word is in flight.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the
// default gains; no clearing pass is needed.
module yuyv_to_rgb888_converter_core #(
    parameter int unsigned COEF_FRAC_BITS = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // command
    input  logic                        start,
    output logic                        busy,
    input  logic [y2r_pkg::PIX_W-1:0]   luma_first,
    input  logic [y2r_pkg::PIX_W-1:0]   chroma_blue,
    input  logic [y2r_pkg::PIX_W-1:0]   luma_second,
    input  logic [y2r_pkg::PIX_W-1:0]   chroma_red,
    // result
    output logic                        done,
    output logic [y2r_pkg::PIX_W-1:0]   red_first,
    output logic [y2r_pkg::PIX_W-1:0]   green_first,
    output logic [y2r_pkg::PIX_W-1:0]   blue_first,
    output logic [y2r_pkg::PIX_W-1:0]   red_second,
    output logic [y2r_pkg::PIX_W-1:0]   green_second,
    output logic [y2r_pkg::PIX_W-1:0]   blue_second,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [y2r_pkg::IDX_W-1:0]   cfg_index,
    input  logic [y2r_pkg::COEF_W-1:0]  cfg_data
);

    localparam int unsigned PW    = y2r_pkg::PIX_W;
    localparam int unsigned DIF_W = PW + 1;
    localparam int unsigned PRD_W = y2r_pkg::COEF_W + 1 + DIF_W;
    localparam int unsigned ACC_W = (COEF_FRAC_BITS + PW + 2 > PRD_W + 3) ?
                                    COEF_FRAC_BITS + PW + 2 : PRD_W + 3;
    localparam int unsigned SH_W  = ACC_W - COEF_FRAC_BITS;

    // Shift right by F (floor) and clamp to a byte
    function automatic logic [PW-1:0] shift_clamp(input logic signed [ACC_W-1:0] acc);
        logic [SH_W-1:0] sh;
        logic [PW-1:0]   res;
        sh = acc[ACC_W-1:COEF_FRAC_BITS];
        if (sh[SH_W-1])
            res = '0;
        else if (|sh[SH_W-2:PW])
            res = y2r_pkg::PIX_MAX;
        else
            res = sh[PW-1:0];
        return res;
    endfunction

    // Luma scaled to the fixed-point grid, widened to the accumulator
    function automatic logic signed [ACC_W-1:0] luma_base(input logic [PW-1:0] y);
        logic [ACC_W-1:0] b;
        b = {{(ACC_W-PW-COEF_FRAC_BITS){1'b0}}, y, {COEF_FRAC_BITS{1'b0}}};
        return $signed(b);
    endfunction

    function automatic logic signed [ACC_W-1:0] sext_prod(input logic signed [PRD_W-1:0] p);
        return $signed({{(ACC_W-PRD_W){p[PRD_W-1]}}, p});
    endfunction

    // Multiplier operands widened to the product width
    function automatic logic signed [PRD_W-1:0] gain_ext(input logic [y2r_pkg::COEF_W-1:0] c);
        return $signed({{(PRD_W-y2r_pkg::COEF_W){1'b0}}, c});
    endfunction

    function automatic logic signed [PRD_W-1:0] dif_ext(input logic signed [DIF_W-1:0] d);
        return $signed({{(PRD_W-DIF_W){d[DIF_W-1]}}, d});
    endfunction

    y2r_pkg::coef_set_t coef_reg;

    // stage 1: captured luma and chroma offsets
    logic                    v1_reg;
    logic [PW-1:0]           s1_y0_reg, s1_y1_reg;
    logic signed [DIF_W-1:0] s1_dcb_reg, s1_dcr_reg;

    // stage 2: gain products
    logic                    v2_reg;
    logic [PW-1:0]           s2_y0_reg, s2_y1_reg;
    logic signed [PRD_W-1:0] s2_red_reg, s2_gcb_reg, s2_gcr_reg, s2_blue_reg;

    // stage 3: full-precision channel sums
    logic                    v3_reg;
    logic signed [ACC_W-1:0] s3_r0_reg, s3_g0_reg, s3_b0_reg;
    logic signed [ACC_W-1:0] s3_r1_reg, s3_g1_reg, s3_b1_reg;

    // stage 4: output word
    logic                    done_reg;
    logic [PW-1:0]           r0_reg, g0_reg, b0_reg, r1_reg, g1_reg, b1_reg;

    logic                    accept;
    logic signed [DIF_W-1:0] dcb_next, dcr_next;
    logic signed [ACC_W-1:0] base0, base1, green_sub;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Chroma offsets, nine-bit signed
    assign dcb_next = $signed({1'b0, chroma_blue}) - $signed({1'b0, y2r_pkg::CHROMA_OFFSET});
    assign dcr_next = $signed({1'b0, chroma_red}) - $signed({1'b0, y2r_pkg::CHROMA_OFFSET});

    // Stage 3 operands
    assign base0     = luma_base(s2_y0_reg);
    assign base1     = luma_base(s2_y1_reg);
    assign green_sub = sext_prod(s2_gcb_reg) + sext_prod(s2_gcr_reg);

    // Gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.cr_to_red   <= y2r_pkg::RST_CR_TO_RED;
            coef_reg.cb_to_green <= y2r_pkg::RST_CB_TO_GREEN;
            coef_reg.cr_to_green <= y2r_pkg::RST_CR_TO_GREEN;
            coef_reg.cb_to_blue  <= y2r_pkg::RST_CB_TO_BLUE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (y2r_pkg::reg_index_t'(cfg_index))
                y2r_pkg::REG_CR_TO_RED:   coef_reg.cr_to_red   <= cfg_data;
                y2r_pkg::REG_CB_TO_GREEN: coef_reg.cb_to_green <= cfg_data;
                y2r_pkg::REG_CR_TO_GREEN: coef_reg.cr_to_green <= cfg_data;
                y2r_pkg::REG_CB_TO_BLUE:  coef_reg.cb_to_blue  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        // stage 1
        if (accept)
        begin
            s1_y0_reg  <= luma_first;
            s1_y1_reg  <= luma_second;
            s1_dcb_reg <= dcb_next;
            s1_dcr_reg <= dcr_next;
        end
        // stage 2: one multiplier per gain
        if (v1_reg)
        begin
            s2_y0_reg   <= s1_y0_reg;
            s2_y1_reg   <= s1_y1_reg;
            s2_red_reg  <= gain_ext(coef_reg.cr_to_red)   * dif_ext(s1_dcr_reg);
            s2_gcb_reg  <= gain_ext(coef_reg.cb_to_green) * dif_ext(s1_dcb_reg);
            s2_gcr_reg  <= gain_ext(coef_reg.cr_to_green) * dif_ext(s1_dcr_reg);
            s2_blue_reg <= gain_ext(coef_reg.cb_to_blue)  * dif_ext(s1_dcb_reg);
        end
        // stage 3
        if (v2_reg)
        begin
            s3_r0_reg <= base0 + sext_prod(s2_red_reg);
            s3_g0_reg <= base0 - green_sub;
            s3_b0_reg <= base0 + sext_prod(s2_blue_reg);
            s3_r1_reg <= base1 + sext_prod(s2_red_reg);
            s3_g1_reg <= base1 - green_sub;
            s3_b1_reg <= base1 + sext_prod(s2_blue_reg);
        end
        // stage 4
        if (v3_reg)
        begin
            r0_reg <= shift_clamp(s3_r0_reg);
            g0_reg <= shift_clamp(s3_g0_reg);
            b0_reg <= shift_clamp(s3_b0_reg);
            r1_reg <= shift_clamp(s3_r1_reg);
            g1_reg <= shift_clamp(s3_g1_reg);
            b1_reg <= shift_clamp(s3_b1_reg);
        end
    end

    assign done         = done_reg;
    assign red_first    = r0_reg;
    assign green_first  = g0_reg;
    assign blue_first   = b0_reg;
    assign red_second   = r1_reg;
    assign green_second = g1_reg;
    assign blue_second  = b1_reg;

endmodule

// ===== test/rgb_pair_checker.sv =====
`timescale 1ns / 100ps

module rgb_pair_checker
    import y2r_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [PIX_W-1:0]    luma_first,
    input  logic [PIX_W-1:0]    chroma_blue,
    input  logic [PIX_W-1:0]    luma_second,
    input  logic [PIX_W-1:0]    chroma_red,
    input  logic                done,
    input  logic [PIX_W-1:0]    red_first,
    input  logic [PIX_W-1:0]    green_first,
    input  logic [PIX_W-1:0]    blue_first,
    input  logic [PIX_W-1:0]    red_second,
    input  logic [PIX_W-1:0]    green_second,
    input  logic [PIX_W-1:0]    blue_second,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [COEF_W-1:0]   cfg_data,
    output int                  mismatches,
    output int                  outstanding
);

    typedef struct packed {
        logic [PIX_W-1:0] red_first;
        logic [PIX_W-1:0] green_first;
        logic [PIX_W-1:0] blue_first;
        logic [PIX_W-1:0] red_second;
        logic [PIX_W-1:0] green_second;
        logic [PIX_W-1:0] blue_second;
    } rgb_pair_t;

    // Local copy of the gain registers and the pixels still due
    coef_set_t  gains;
    rgb_pair_t  pending_pixels[$];

    // Floor shift by the fraction width, then saturate to a byte
    function automatic logic [PIX_W-1:0] floor_clamp(input longint acc);
        longint v;
        v = acc >>> FRAC_BITS;
        if (v > longint'(PIX_MAX))
            return PIX_MAX;
        if (v < 0)
            return '0;
        return v[PIX_W-1:0];
    endfunction

    // Both pixels of one macropixel share the chroma terms
    function automatic rgb_pair_t convert_macropixel(
        input coef_set_t        g,
        input logic [PIX_W-1:0] y0,
        input logic [PIX_W-1:0] cb,
        input logic [PIX_W-1:0] y1,
        input logic [PIX_W-1:0] cr
    );
        longint    d_cb;
        longint    d_cr;
        longint    red_add;
        longint    green_sub;
        longint    blue_add;
        longint    base0;
        longint    base1;
        rgb_pair_t px;
        d_cb      = longint'(cb) - longint'(CHROMA_OFFSET);
        d_cr      = longint'(cr) - longint'(CHROMA_OFFSET);
        red_add   = longint'(g.cr_to_red) * d_cr;
        green_sub = longint'(g.cb_to_green) * d_cb + longint'(g.cr_to_green) * d_cr;
        blue_add  = longint'(g.cb_to_blue) * d_cb;
        base0     = longint'(y0) * (longint'(1) << FRAC_BITS);
        base1     = longint'(y1) * (longint'(1) << FRAC_BITS);
        px.red_first    = floor_clamp(base0 + red_add);
        px.green_first  = floor_clamp(base0 - green_sub);
        px.blue_first   = floor_clamp(base0 + blue_add);
        px.red_second   = floor_clamp(base1 + red_add);
        px.green_second = floor_clamp(base1 - green_sub);
        px.blue_second  = floor_clamp(base1 + blue_add);
        return px;
    endfunction

    // Returns 1 on a mismatch
    function automatic int channel_differs(
        input string            name,
        input logic [PIX_W-1:0] want,
        input logic [PIX_W-1:0] got
    );
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Retire results, queue predictions, track gain writes
    always @(posedge clk or negedge rst_n)
    begin
        int        errs;
        rgb_pair_t want;
        if (!rst_n)
        begin
            gains = '{cr_to_red:   RST_CR_TO_RED,
                      cb_to_green: RST_CB_TO_GREEN,
                      cr_to_green: RST_CR_TO_GREEN,
                      cb_to_blue:  RST_CB_TO_BLUE};
            pending_pixels.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (done)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errs++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    errs += channel_differs("red_first", want.red_first, red_first);
                    errs += channel_differs("green_first", want.green_first, green_first);
                    errs += channel_differs("blue_first", want.blue_first, blue_first);
                    errs += channel_differs("red_second", want.red_second, red_second);
                    errs += channel_differs("green_second", want.green_second,
                                            green_second);
                    errs += channel_differs("blue_second", want.blue_second, blue_second);
                end
            end
            if (start && !busy)
                pending_pixels.push_back(convert_macropixel(gains, luma_first, chroma_blue,
                                                            luma_second, chroma_red));
            // indexes past the map are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (reg_index_t'(cfg_index))
                    REG_CR_TO_RED:   gains.cr_to_red   = cfg_data;
                    REG_CB_TO_GREEN: gains.cb_to_green = cfg_data;
                    REG_CR_TO_GREEN: gains.cr_to_green = cfg_data;
                    REG_CB_TO_BLUE:  gains.cb_to_blue  = cfg_data;
                    default: ;
                endcase
            end
            mismatches  <= mismatches + errs;
            outstanding <= pending_pixels.size();
        end
    end

endmodule

// ===== test/yuyv_to_rgb888_converter_core_test.sv =====
`timescale 1ns / 100ps

module yuyv_to_rgb888_converter_core_test;

    import y2r_pkg::*;

    localparam int unsigned FRAC_BITS       = 14;
    localparam int          PIPE_DEPTH      = 4;    // accepting edge to result edge
    localparam int          WORDS_PER_PHASE = 210;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic [PIX_W-1:0]   luma_first   = '0;
    logic [PIX_W-1:0]   chroma_blue  = '0;
    logic [PIX_W-1:0]   luma_second  = '0;
    logic [PIX_W-1:0]   chroma_red   = '0;
    logic               done;
    logic [PIX_W-1:0]   red_first;
    logic [PIX_W-1:0]   green_first;
    logic [PIX_W-1:0]   blue_first;
    logic [PIX_W-1:0]   red_second;
    logic [PIX_W-1:0]   green_second;
    logic [PIX_W-1:0]   blue_second;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index    = '0;
    logic [COEF_W-1:0]  cfg_data     = '0;

    int                 mismatches;
    int                 outstanding;
    int                 words_sent    = 0;
    int                 gain_settings = 1;
    bit                 gaps_on       = 1'b1;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    yuyv_to_rgb888_converter_core #(
        .COEF_FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .luma_first   (luma_first),
        .chroma_blue  (chroma_blue),
        .luma_second  (luma_second),
        .chroma_red   (chroma_red),
        .done         (done),
        .red_first    (red_first),
        .green_first  (green_first),
        .blue_first   (blue_first),
        .red_second   (red_second),
        .green_second (green_second),
        .blue_second  (blue_second),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rgb_pair_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) pixel_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .luma_first   (luma_first),
        .chroma_blue  (chroma_blue),
        .luma_second  (luma_second),
        .chroma_red   (chroma_red),
        .done         (done),
        .red_first    (red_first),
        .green_first  (green_first),
        .blue_first   (blue_first),
        .red_second   (red_second),
        .green_second (green_second),
        .blue_second  (blue_second),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Byte with extra weight on the edges and the chroma midpoint
    function automatic logic [PIX_W-1:0] any_byte();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PIX_MAX;
            2:       return CHROMA_OFFSET;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // One macropixel word; busy is read at the falling edge where it is settled
    task automatic send_word(
        input logic [PIX_W-1:0] y0,
        input logic [PIX_W-1:0] cb,
        input logic [PIX_W-1:0] y1,
        input logic [PIX_W-1:0] cr
    );
        start       <= 1'b1;
        luma_first  <= y0;
        chroma_blue <= cb;
        luma_second <= y1;
        chroma_red  <= cr;
        do @(negedge clk); while (busy);
        @(posedge clk);
        words_sent++;
        // occasional gap, with junk on the idle bus
        if (gaps_on && $urandom_range(0, 99) < 10)
        begin
            start       <= 1'b0;
            luma_first  <= PIX_W'($urandom);
            chroma_blue <= PIX_W'($urandom);
            luma_second <= PIX_W'($urandom);
            chroma_red  <= PIX_W'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Hold off until every pixel pair is back, then let the pipe settle
    task automatic drain();
        start <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count)
        begin
            send_word(any_byte(), any_byte(), any_byte(), any_byte());
            if ($urandom_range(0, 199) == 0)
                drain();
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
    endtask

    // All four gains, then the unmapped indexes which must change nothing
    task automatic load_gains(input coef_set_t g);
        write_reg(REG_CR_TO_RED, g.cr_to_red);
        write_reg(REG_CB_TO_GREEN, g.cb_to_green);
        write_reg(REG_CR_TO_GREEN, g.cr_to_green);
        write_reg(REG_CB_TO_BLUE, g.cb_to_blue);
        for (int k = int'(REG_CB_TO_BLUE) + 1; k < (1 << IDX_W); k++)
            write_reg(IDX_W'(k), COEF_W'($urandom));
        cfg_valid <= 1'b0;
        gain_settings++;
    endtask

    function automatic coef_set_t random_gains();
        coef_set_t g;
        g.cr_to_red   = COEF_W'($urandom);
        g.cb_to_green = COEF_W'($urandom);
        g.cr_to_green = COEF_W'($urandom);
        g.cb_to_blue  = COEF_W'($urandom);
        return g;
    endfunction

    initial
    begin
        coef_set_t unity;
        coef_set_t defaults;
        unity    = '{cr_to_red:   COEF_W'(1 << FRAC_BITS),
                     cb_to_green: COEF_W'(1 << FRAC_BITS),
                     cr_to_green: COEF_W'(1 << FRAC_BITS),
                     cb_to_blue:  COEF_W'(1 << FRAC_BITS)};
        defaults = '{cr_to_red:   RST_CR_TO_RED,
                     cb_to_green: RST_CB_TO_GREEN,
                     cr_to_green: RST_CR_TO_GREEN,
                     cb_to_blue:  RST_CB_TO_BLUE};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset gains: grey axis, saturation both ways
        send_word(8'd0,   8'd128, 8'd0,   8'd128);
        send_word(8'd255, 8'd128, 8'd255, 8'd128);
        send_word(8'd0,   8'd0,   8'd0,   8'd0);
        send_word(8'd255, 8'd255, 8'd255, 8'd255);
        send_word(8'd0,   8'd255, 8'd255, 8'd0);
        send_word(8'd255, 8'd0,   8'd0,   8'd255);
        send_word(8'd0,   8'd128, 8'd255, 8'd128);
        send_word(8'd128, 8'd0,   8'd128, 8'd255);
        send_word(8'd128, 8'd255, 8'd128, 8'd0);
        send_word(8'd127, 8'd127, 8'd128, 8'd129);
        send_word(8'd128, 8'd129, 8'd127, 8'd127);
        send_word(8'h55,  8'haa,  8'haa,  8'h55);
        send_word(8'haa,  8'h55,  8'h55,  8'haa);
        send_word(8'd16,  8'd128, 8'd235, 8'd128);
        send_word(8'd1,   8'd1,   8'd254, 8'd254);
        send_word(8'd254, 8'd254, 8'd1,   8'd1);
        drain();
        run_random(WORDS_PER_PHASE);
        drain();

        // Zero gains: output follows luma
        load_gains('0);
        run_random(WORDS_PER_PHASE);
        drain();

        // Full-scale gains: largest products
        load_gains('1);
        run_random(WORDS_PER_PHASE);
        drain();

        // Unity gains, back-to-back with random gaps off
        gaps_on = 1'b0;
        load_gains(unity);
        run_random(WORDS_PER_PHASE);
        drain();
        gaps_on = 1'b1;

        repeat (3)
        begin
            load_gains(random_gains());
            run_random(WORDS_PER_PHASE);
            drain();
        end

        // Reset gains written back explicitly
        load_gains(defaults);
        run_random(WORDS_PER_PHASE);
        drain();

        $display("Converted %0d macropixels under %0d gain settings,", words_sent,
                 gain_settings);
        $display("covering zero, unity, full-scale and random gains with clamping at both ends.");
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/y2r_pkg.sv
rtl/core/yuyv_to_rgb888_converter_core.sv
test/rgb_pair_checker.sv
test/yuyv_to_rgb888_converter_core_test.sv
